/* hw/rtl/qspd_pkg.sv */
// Shared types, constants and byte classifiers for the query string decoder.
// Used by qspd_decode and query_string_percent_decoder; no dependencies.
package qspd_pkg;

   localparam int HoldDepth = 32;
   localparam int CountW    = $clog2(HoldDepth + 1);
   localparam int IdxW      = (HoldDepth > 1) ? $clog2(HoldDepth) : 1;

   localparam logic [7:0] ChTab     = 8'h09;
   localparam logic [7:0] ChLf      = 8'h0A;
   localparam logic [7:0] ChVt      = 8'h0B;
   localparam logic [7:0] ChFf      = 8'h0C;
   localparam logic [7:0] ChCr      = 8'h0D;
   localparam logic [7:0] ChSpace   = 8'h20;
   localparam logic [7:0] ChPercent = 8'h25;
   localparam logic [7:0] ChPlus    = 8'h2B;
   localparam logic [7:0] ChMinus   = 8'h2D;

   // held whitespace codes
   localparam logic [1:0] WsTab = 2'd0;
   localparam logic [1:0] WsCr  = 2'd1;
   localparam logic [1:0] WsLf  = 2'd2;

   // escape progress: none open, waiting first char, waiting second char
   localparam logic [1:0] EscIdle   = 2'd0;
   localparam logic [1:0] EscFirst  = 2'd1;
   localparam logic [1:0] EscSecond = 2'd2;

   typedef enum logic [2:0] {
      StIdle,
      StPlus,
      StHeld,
      StByte,
      StTail,
      StFlush
   } state_type;

   typedef struct packed {
      logic [1:0] cnt;
      logic [7:0] first;
   } esc_type;

   typedef struct packed {
      logic       emit;
      logic [7:0] value;
      esc_type    esc;
   } dec_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic logic is_trim(input logic [7:0] b);
      return (b == ChTab) || (b == ChCr) || (b == ChLf);
   endfunction

   function automatic logic [1:0] ws_code(input logic [7:0] b);
      return (b == ChCr) ? WsCr : ((b == ChLf) ? WsLf : WsTab);
   endfunction

   function automatic logic [7:0] ws_byte(input logic [1:0] c);
      return (c == WsCr) ? ChCr : ((c == WsLf) ? ChLf : ChTab);
   endfunction

   function automatic hex_type hex_val(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         h.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         h.value = 4'(c - 8'h37);
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == ChSpace) || (c == ChTab) || (c == ChLf) || (c == ChVt) ||
             (c == ChFf) || (c == ChCr);
   endfunction

endpackage

/* hw/rtl/qspd_decode.sv */
// Shared percent-escape decode unit: one raw byte per use, '+' mapping included.
// Depends on qspd_pkg.
module qspd_decode (
   input  logic [7:0]       raw,
   input  qspd_pkg::esc_type esc,
   output qspd_pkg::dec_type dec
);
   import qspd_pkg::*;

   logic [7:0] b;
   hex_type    h1;
   hex_type    h2;
   logic [7:0] pair;

   assign b  = (raw == ChPlus) ? ChSpace : raw;
   assign h1 = hex_val(esc.first);
   assign h2 = hex_val(b);

   // two-char strtol base 16 value, low byte
   always_comb begin
      if (h1.valid) begin
         pair = h2.valid ? {h1.value, h2.value} : {4'd0, h1.value};
      end else if (!h2.valid) begin
         pair = 8'd0;
      end else if (is_space(esc.first)) begin
         pair = {4'd0, h2.value};
      end else if (esc.first == ChMinus) begin
         pair = 8'd0 - {4'd0, h2.value};
      end else begin
         pair = 8'd0;
      end
   end

   always_comb begin
      dec.emit  = 1'b0;
      dec.value = b;
      dec.esc   = esc;
      unique case (esc.cnt)
         EscFirst: begin
            dec.esc.first = b;
            dec.esc.cnt   = EscSecond;
         end
         EscSecond: begin
            dec.value = pair;
            if (pair == ChPercent) begin
               dec.esc.cnt = EscFirst;
            end else begin
               dec.esc.cnt = EscIdle;
               dec.emit    = (pair != 8'd0);
            end
         end
         default: begin
            if (b == ChPercent) begin
               dec.esc.cnt = EscFirst;
            end else begin
               dec.esc.cnt = EscIdle;
               dec.emit    = 1'b1;
            end
         end
      endcase
   end

endmodule

/* hw/rtl/query_string_percent_decoder.sv */
// Top level: sequencer, held whitespace run and output staging.
// Depends on qspd_pkg and qspd_decode.
//
//  Channel  Dir  tdata            tuser                          tlast
//  req_     in   in_byte[7:0]     -                              is_last
//  rsp_     out  out_byte[7:0]    [0] byte_valid [1] held_overflow end_of_string
//
// A word is taken only in the idle state. A tab/CR/LF that is held or dropped,
// or a leading '+', is done with on acceptance; as the last word of a string
// it also passes the tail and flush states. A content byte then passes, in
// order, a decode step for a pending '+', one per held byte, one for itself,
// the tail state on the last word of a string and the flush state. The single
// decode unit takes these steps one after another.
// Reset is synchronous and clears all control state; the held run has no
// clearing pass. A stalled rsp_ side stalls the sequencer when a new result
// meets a full staging register and a full output register, and holds the
// flush cycle until the output register frees up.
module query_string_percent_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] held_overflow
   output logic       rsp_tlast
);
   import qspd_pkg::*;

   state_type         state_ff, state_in;
   logic [7:0]        byte_ff, byte_in;
   logic              last_ff, last_in;
   logic              ovf_ff, ovf_in;
   logic [IdxW-1:0]   idx_ff, idx_in;
   logic [CountW-1:0] count_ff, count_in;
   logic              leading_ff, leading_in;
   logic              plus_ff, plus_in;
   esc_type           esc_ff, esc_in;

   // one staged result, so the final one can still be marked end of string
   logic              pend_valid_ff, pend_valid_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic              pend_ovf_ff, pend_ovf_in;

   logic              out_valid_ff, out_valid_in;
   logic [7:0]        out_byte_ff, out_byte_in;
   logic              out_bv_ff, out_bv_in;
   logic              out_eos_ff, out_eos_in;
   logic              out_ovf_ff, out_ovf_in;

   logic [1:0]        held_ff [HoldDepth];
   logic [1:0]        held_rd_ff;
   logic              held_we;

   logic [7:0]        dec_raw;
   dec_type           dec;
   hex_type           tail_hex;
   logic              step_emit;
   logic [7:0]        step_value;
   logic              step_stall;
   logic              out_free;
   logic              accept;
   logic              work;

   qspd_decode u_decode (
      .raw (dec_raw),
      .esc (esc_ff),
      .dec (dec)
   );

   assign req_tready = (state_ff == StIdle);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_ovf_ff, out_bv_ff};
   assign rsp_tlast  = out_eos_ff;

   assign tail_hex = hex_val(esc_ff.first);

   // decode operand select
   always_comb begin
      unique case (state_ff)
         StPlus:  dec_raw = ChPlus;
         StHeld:  dec_raw = ws_byte(held_rd_ff);
         default: dec_raw = byte_ff;
      endcase
   end

   // a one-char escape left open at end of string parses on its first char
   always_comb begin
      if (state_ff == StTail) begin
         step_emit  = (esc_ff.cnt == EscSecond) && tail_hex.valid &&
                      (tail_hex.value != 4'd0);
         step_value = {4'd0, tail_hex.value};
      end else begin
         step_emit  = dec.emit;
         step_value = dec.value;
      end
   end

   assign step_stall = step_emit && pend_valid_ff && !out_free;

   // content byte, or a trim byte that overflows the held run
   assign work = !is_trim(req_tdata) ?
                    !(leading_ff && (req_tdata == ChPlus)) :
                    (!leading_ff && !req_tlast && (count_ff == CountW'(HoldDepth)));

   always_comb begin
      state_in      = state_ff;
      byte_in       = byte_ff;
      last_in       = last_ff;
      ovf_in        = ovf_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      leading_in    = leading_ff;
      plus_in       = plus_ff;
      esc_in        = esc_ff;
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      pend_ovf_in   = pend_ovf_ff;
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_bv_in     = out_bv_ff;
      out_eos_in    = out_eos_ff;
      out_ovf_in    = out_ovf_ff;
      held_we       = 1'b0;

      unique case (state_ff)
         StIdle: begin
            if (accept) begin
               byte_in = req_tdata;
               last_in = req_tlast;
               ovf_in  = is_trim(req_tdata);
               idx_in  = '0;
               if (work) begin
                  leading_in = 1'b0;
                  if (plus_ff) begin
                     state_in = StPlus;
                  end else if (count_ff != '0) begin
                     state_in = StHeld;
                  end else begin
                     state_in = StByte;
                  end
               end else if (is_trim(req_tdata)) begin
                  if (!leading_ff && !req_tlast) begin
                     held_we  = 1'b1;
                     count_in = count_ff + CountW'(1);
                  end else if (req_tlast) begin
                     state_in = StTail;
                  end
               end else if (!req_tlast) begin
                  // leading '+': hold it until content shows up
                  leading_in = 1'b0;
                  plus_in    = 1'b1;
               end else begin
                  state_in = StTail;
               end
            end
         end
         StPlus, StHeld, StByte, StTail: begin
            if (!step_stall) begin
               if (state_ff != StTail) begin
                  esc_in = dec.esc;
               end
               if (step_emit) begin
                  if (pend_valid_ff) begin
                     out_valid_in = 1'b1;
                     out_byte_in  = pend_byte_ff;
                     out_bv_in    = 1'b1;
                     out_eos_in   = 1'b0;
                     out_ovf_in   = pend_ovf_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_byte_in  = step_value;
                  pend_ovf_in   = ovf_ff && (state_ff != StTail);
               end
               unique case (state_ff)
                  StPlus: begin
                     plus_in  = 1'b0;
                     state_in = (count_ff != '0) ? StHeld : StByte;
                  end
                  StHeld: begin
                     if (CountW'(idx_ff) == count_ff - CountW'(1)) begin
                        count_in = '0;
                        idx_in   = '0;
                        state_in = StByte;
                     end else begin
                        idx_in = idx_ff + IdxW'(1);
                     end
                  end
                  StByte:  state_in = last_ff ? StTail : StFlush;
                  default: state_in = StFlush;
               endcase
            end
         end
         StFlush: begin
            if (last_ff) begin
               if (out_free) begin
                  out_valid_in  = 1'b1;
                  out_byte_in   = pend_valid_ff ? pend_byte_ff : 8'd0;
                  out_bv_in     = pend_valid_ff;
                  out_eos_in    = 1'b1;
                  out_ovf_in    = pend_valid_ff && pend_ovf_ff;
                  pend_valid_in = 1'b0;
                  leading_in    = 1'b1;
                  count_in      = '0;
                  plus_in       = 1'b0;
                  esc_in        = '{cnt: EscIdle, first: 8'd0};
                  state_in      = StIdle;
               end
            end else if (!pend_valid_ff) begin
               state_in = StIdle;
            end else if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = pend_byte_ff;
               out_bv_in     = 1'b1;
               out_eos_in    = 1'b0;
               out_ovf_in    = pend_ovf_ff;
               pend_valid_in = 1'b0;
               state_in      = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= StIdle;
         count_ff      <= '0;
         leading_ff    <= 1'b1;
         plus_ff       <= 1'b0;
         esc_ff        <= '{cnt: EscIdle, first: 8'd0};
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         leading_ff    <= leading_in;
         plus_ff       <= plus_in;
         esc_ff        <= esc_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      last_ff      <= last_in;
      ovf_ff       <= ovf_in;
      pend_byte_ff <= pend_byte_in;
      pend_ovf_ff  <= pend_ovf_in;
      out_byte_ff  <= out_byte_in;
      out_bv_ff    <= out_bv_in;
      out_eos_ff   <= out_eos_in;
      out_ovf_ff   <= out_ovf_in;
   end

   // held run storage; registered read, addressed by the next index
   always_ff @(posedge clock) begin
      if (held_we) begin
         held_ff[count_ff[IdxW-1:0]] <= ws_code(req_tdata);
      end
      held_rd_ff <= held_ff[idx_in];
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(HoldDepth))
      else $error("held run count beyond depth");

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("staged result left over at idle");

   a_held_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == StHeld |-> (count_ff != '0) && (CountW'(idx_ff) < count_ff))
      else $error("held read index out of run");

   a_bare_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast && !rsp_tuser[1])
      else $error("bare marker without end of string");

   a_esc_code: assert property (@(posedge clock) disable iff (reset)
      (esc_ff.cnt == EscIdle) || (esc_ff.cnt == EscFirst) || (esc_ff.cnt == EscSecond))
      else $error("escape progress code out of range");

endmodule
